[sv/jsu_pkg.sv]
package jsu_pkg;

  localparam int unsigned CHAR_W = 21;
  localparam int unsigned HEX_W  = 16;
  localparam int unsigned STAT_W = 2;

  // Scanner modes; code 7 is unused and is treated as waiting.
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HEX4   = 3'd2,
    MODE_HEX3   = 3'd3,
    MODE_HEX2   = 3'd4,
    MODE_HEX1   = 3'd5,
    MODE_WAIT   = 3'd6
  } mode_t;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_CHAR = 2'd0;
  localparam logic [STAT_W-1:0] ST_OK   = 2'd1;
  localparam logic [STAT_W-1:0] ST_ERR  = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL       = 21'h00;
  localparam logic [CHAR_W-1:0] CH_TAB       = 21'h09;
  localparam logic [CHAR_W-1:0] CH_BS        = 21'h08;
  localparam logic [CHAR_W-1:0] CH_FF        = 21'h0C;
  localparam logic [CHAR_W-1:0] CH_LF        = 21'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 21'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 21'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE     = 21'h22;
  localparam logic [CHAR_W-1:0] CH_SLASH     = 21'h2F;
  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 21'h5C;
  localparam logic [CHAR_W-1:0] CH_0         = 21'h30;
  localparam logic [CHAR_W-1:0] CH_9         = 21'h39;
  localparam logic [CHAR_W-1:0] CH_UA        = 21'h41;
  localparam logic [CHAR_W-1:0] CH_UF        = 21'h46;
  localparam logic [CHAR_W-1:0] CH_LA        = 21'h61;
  localparam logic [CHAR_W-1:0] CH_LB        = 21'h62;
  localparam logic [CHAR_W-1:0] CH_LF_LETTER = 21'h66;
  localparam logic [CHAR_W-1:0] CH_LN        = 21'h6E;
  localparam logic [CHAR_W-1:0] CH_LR        = 21'h72;
  localparam logic [CHAR_W-1:0] CH_LT        = 21'h74;
  localparam logic [CHAR_W-1:0] CH_LU        = 21'h75;

  // Outcome of one character: next scanner state and the optional result.
  typedef struct packed {
    logic              emit;
    logic [CHAR_W-1:0] ch;
    logic [STAT_W-1:0] status;
    mode_t             mode;
    logic [HEX_W-1:0]  hex;
  } step_t;

endpackage

[sv/jsu_decode.sv]
module jsu_decode (
  input  jsu_pkg::mode_t                mode_i,
  input  logic [jsu_pkg::HEX_W-1:0]     hex_i,
  input  logic [jsu_pkg::CHAR_W-1:0]    char_i,
  output jsu_pkg::step_t                step_o
);

  logic       dig_ok;
  logic [3:0] dig;
  logic [jsu_pkg::HEX_W-1:0] hex_shift;

  // Hex digit value, either case
  always_comb begin
    dig_ok = 1'b1;
    dig    = 4'd0;
    priority if (char_i >= jsu_pkg::CH_0 && char_i <= jsu_pkg::CH_9) begin
      dig = char_i[3:0];
    end else if ((char_i >= jsu_pkg::CH_UA && char_i <= jsu_pkg::CH_UF) ||
                 (char_i >= jsu_pkg::CH_LA && char_i <= jsu_pkg::CH_LF_LETTER)) begin
      dig = char_i[3:0] + 4'd9;
    end else begin
      dig_ok = 1'b0;
    end
  end

  assign hex_shift = {hex_i[jsu_pkg::HEX_W-5:0], dig};

  always_comb begin
    step_o        = '0;
    step_o.mode   = mode_i;
    step_o.hex    = hex_i;
    step_o.status = jsu_pkg::ST_CHAR;
    unique case (mode_i)
      jsu_pkg::MODE_NORMAL: begin
        priority if (char_i == jsu_pkg::CH_NUL) begin
          step_o.emit = 1'b1; step_o.status = jsu_pkg::ST_ERR;
          step_o.mode = jsu_pkg::MODE_WAIT; step_o.hex = '0;
        end else if (char_i == jsu_pkg::CH_BACKSLASH) begin
          step_o.mode = jsu_pkg::MODE_ESCAPE;
        end else if (char_i == jsu_pkg::CH_QUOTE) begin
          step_o.emit = 1'b1; step_o.status = jsu_pkg::ST_OK;
          step_o.mode = jsu_pkg::MODE_WAIT; step_o.hex = '0;
        end else if (char_i < jsu_pkg::CH_SPACE && char_i != jsu_pkg::CH_TAB) begin
          step_o.emit = 1'b1; step_o.status = jsu_pkg::ST_ERR;
          step_o.mode = jsu_pkg::MODE_WAIT; step_o.hex = '0;
        end else begin
          step_o.emit = 1'b1; step_o.ch = char_i;
        end
      end
      jsu_pkg::MODE_ESCAPE: begin
        step_o.emit = 1'b1;
        step_o.mode = jsu_pkg::MODE_NORMAL;
        unique case (char_i)
          jsu_pkg::CH_QUOTE:     step_o.ch = jsu_pkg::CH_QUOTE;
          jsu_pkg::CH_BACKSLASH: step_o.ch = jsu_pkg::CH_BACKSLASH;
          jsu_pkg::CH_SLASH:     step_o.ch = jsu_pkg::CH_SLASH;
          jsu_pkg::CH_LB:        step_o.ch = jsu_pkg::CH_BS;
          jsu_pkg::CH_LF_LETTER: step_o.ch = jsu_pkg::CH_FF;
          jsu_pkg::CH_LN:        step_o.ch = jsu_pkg::CH_LF;
          jsu_pkg::CH_LR:        step_o.ch = jsu_pkg::CH_CR;
          jsu_pkg::CH_LT:        step_o.ch = jsu_pkg::CH_TAB;
          jsu_pkg::CH_LU: begin
            step_o.emit = 1'b0;
            step_o.mode = jsu_pkg::MODE_HEX4;
            step_o.hex  = '0;
          end
          default: begin
            step_o.status = jsu_pkg::ST_ERR;
            step_o.mode   = jsu_pkg::MODE_WAIT;
            step_o.hex    = '0;
          end
        endcase
      end
      jsu_pkg::MODE_HEX4, jsu_pkg::MODE_HEX3, jsu_pkg::MODE_HEX2,
      jsu_pkg::MODE_HEX1: begin
        priority if (!dig_ok) begin
          step_o.emit = 1'b1; step_o.status = jsu_pkg::ST_ERR;
          step_o.mode = jsu_pkg::MODE_WAIT; step_o.hex = '0;
        end else if (mode_i == jsu_pkg::MODE_HEX1) begin
          step_o.emit = 1'b1;
          step_o.ch   = {{(jsu_pkg::CHAR_W-jsu_pkg::HEX_W){1'b0}}, hex_shift};
          step_o.mode = jsu_pkg::MODE_NORMAL;
          step_o.hex  = '0;
        end else begin
          step_o.hex  = hex_shift;
          step_o.mode = jsu_pkg::mode_t'(mode_i + 3'd1);
        end
      end
      default: begin
        // waiting for an opening quote (also the unused code)
        if (char_i == jsu_pkg::CH_QUOTE) begin
          step_o.mode = jsu_pkg::MODE_NORMAL;
          step_o.hex  = '0;
        end else begin
          step_o.mode = jsu_pkg::MODE_WAIT;
        end
      end
    endcase
  end

endmodule

[sv/json_string_unescape.sv]
// Channel  | Ports                                    | Direction
// ---------+------------------------------------------+----------
// input    | in_valid, in_ready, in_char_code[20:0]   | in
// result   | out_valid, out_ready, out_char[20:0],    | out
//          | out_status[1:0]                          |
//
// One character per cycle sustained while results are taken; a request waits in the input
// register and its result (if any) is written to the output register as it leaves there.
// Mode and hex accumulator update as a character leaves the input register.
// Reset (rst_n low, synchronous) empties both registers; scanner starts in normal mode.
// A stall on out_ready holds the input register; in_ready drops only when both
// registers are full and the result is not being taken.
module json_string_unescape (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [jsu_pkg::CHAR_W-1:0]    in_char_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [jsu_pkg::CHAR_W-1:0]    out_char,
  output logic [jsu_pkg::STAT_W-1:0]    out_status
);

  // Input register
  logic                       in_vld_r;
  logic [jsu_pkg::CHAR_W-1:0] in_char_r;

  // Scanner state
  jsu_pkg::mode_t             mode_r;
  logic [jsu_pkg::HEX_W-1:0]  hex_r;

  // Result register
  logic                       out_vld_r;
  logic [jsu_pkg::CHAR_W-1:0] out_char_r;
  logic [jsu_pkg::STAT_W-1:0] out_status_r;

  jsu_pkg::step_t step;
  logic           adv;     // character in the input register is processed
  logic           slot_free;

  jsu_decode u_decode (
    .mode_i (mode_r),
    .hex_i  (hex_r),
    .char_i (in_char_r),
    .step_o (step)
  );

  assign slot_free = !out_vld_r || out_ready;
  assign adv       = in_vld_r && slot_free;
  assign in_ready  = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      mode_r    <= jsu_pkg::MODE_NORMAL;
      hex_r     <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        mode_r <= step.mode;
        hex_r  <= step.hex;
      end
      if (slot_free) begin
        // a character that gives no result leaves the slot empty
        out_vld_r <= adv && step.emit;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_char_r <= in_char_code;
    end
    if (adv && step.emit) begin
      out_char_r   <= step.ch;
      out_status_r <= step.status;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_char   = out_char_r;
  assign out_status = out_status_r;

endmodule
